/* design/scrolling_seven_segment_marquee_unit_assert.svh */
// ----------------------------------------------------------------------------
// marquee assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCROLLING_SEVEN_SEGMENT_MARQUEE_UNIT_ASSERT_SVH
`define SCROLLING_SEVEN_SEGMENT_MARQUEE_UNIT_ASSERT_SVH

// same-cycle implication
`define SSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// shared widths, register indexes and the segment font of the marquee
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int CODE_W   = 8;
  localparam int BANK_W   = 24;
  localparam int DIGITS   = 6;
  localparam int CNT_W    = $clog2(DIGITS);
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;
  localparam int PERIOD_W = 20;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;
  localparam int REGSEL_W = 2;

  localparam logic [REGSEL_W-1:0] REG_MSG_LO = 2'd0;
  localparam logic [REGSEL_W-1:0] REG_MSG_HI = 2'd1;
  localparam logic [REGSEL_W-1:0] REG_LENGTH = 2'd2;
  localparam logic [REGSEL_W-1:0] REG_PERIOD = 2'd3;

  localparam logic [LEN_W-1:0]    RESET_LENGTH = 5'd10;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 20'd5000;
  localparam logic [BANK_W-1:0]   BLANK_BANK   = 24'hFFFFFF;

  localparam logic [CODE_W-1:0] CODE_BLANK = 8'hFF;
  localparam logic [CODE_W-1:0] CODE_DASH  = 8'hBF;
  localparam logic [CODE_W-1:0] CODE_DOT   = 8'h7F;
  localparam logic [CODE_W-1:0] CODE_UNDER = 8'hE7;
  localparam logic [CODE_W-1:0] CODE_QUEST = 8'h86;

  localparam logic [CODE_W-1:0] LETTER_FONT [26] = '{
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hF9, 8'hE1, 8'h89, 8'hC7, 8'hC8,
    8'hAB, 8'hC0, 8'h8C, 8'h98, 8'hAF, 8'h92, 8'h87, 8'hC1, 8'hC1, 8'hC1, 8'h89, 8'h91, 8'hA4
  };

  localparam logic [CODE_W-1:0] DIGIT_FONT [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  function automatic logic [CODE_W-1:0] encode_char(input logic [7:0] ch);
    logic [CODE_W-1:0] code;
    code = CODE_BLANK;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      code = LETTER_FONT[5'(ch - 8'h41)];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      code = LETTER_FONT[5'(ch - 8'h61)];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      code = DIGIT_FONT[4'(ch - 8'h30)];
    end else if (ch == 8'h2D) begin
      code = CODE_DASH;
    end else if (ch == 8'h2E) begin
      code = CODE_DOT;
    end else if (ch == 8'h5F) begin
      code = CODE_UNDER;
    end else if (ch == 8'h3F) begin
      code = CODE_QUEST;
    end
    return code;
  endfunction

endpackage

/* design/ssm_in_if.sv */
// ----------------------------------------------------------------------------
// ssm_in_if
// tick channel: two switch bits per beat
// ----------------------------------------------------------------------------
interface ssm_in_if;
  logic valid;
  logic ready;
  logic display_enable;
  logic scroll_enable;

  modport source (output valid, output display_enable, output scroll_enable, input ready);
  modport sink   (input valid, input display_enable, input scroll_enable, output ready);
endinterface

/* design/ssm_out_if.sv */
// ----------------------------------------------------------------------------
// ssm_out_if
// display channel: two banks of three active-low segment codes per beat
// ----------------------------------------------------------------------------
interface ssm_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssm_pkg::BANK_W-1:0] right_digits;
  logic [ssm_pkg::BANK_W-1:0] left_digits;

  modport source (output valid, output right_digits, output left_digits, input ready);
  modport sink   (input valid, input right_digits, input left_digits, output ready);
endinterface

/* design/scrolling_seven_segment_marquee_unit.sv */
// a tick that does not redraw goes from accept straight to the hand-off to the output
// register; one that redraws the window takes accept, six digit steps, then that hand-off
// no new tick before the last is handed off; the shared encoder does one digit per cycle
// reset: synchronous active-low rst_n; display blank, position and tick count zero,
// registers back to length 10 and period 5000
// ----------------------------------------------------------------------------
// scrolling_seven_segment_marquee_unit
// six-digit scrolling text marquee with an apb-style register port; a small
// sequencer runs one index/encode unit over the six window characters
// ----------------------------------------------------------------------------
`include "scrolling_seven_segment_marquee_unit_assert.svh"

module scrolling_seven_segment_marquee_unit #(
  parameter int MESSAGE_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ssm_in_if.sink                        in_ch,
  ssm_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssm_pkg::ADDR_W-1:0]    paddr,
  input  logic [ssm_pkg::DATA_W-1:0]    pwdata,
  output logic [ssm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [ssm_pkg::LEN_W-1:0] LEN_MAX  = ssm_pkg::LEN_W'(MESSAGE_MAX);
  localparam logic [ssm_pkg::CNT_W-1:0] CNT_LAST = ssm_pkg::CNT_W'(ssm_pkg::DIGITS - 1);
  localparam int WIN_W = ssm_pkg::DIGITS * ssm_pkg::CODE_W;
  localparam int MOD_W = ssm_pkg::LEN_W + ssm_pkg::POS_W;

  logic [1:0] state_r, state_nxt;

  logic [ssm_pkg::DATA_W-1:0]   message_chars_lo_r;
  logic [ssm_pkg::DATA_W-1:0]   message_chars_hi_r;
  logic [ssm_pkg::LEN_W-1:0]    message_length_r;
  logic [ssm_pkg::PERIOD_W-1:0] scroll_period_r;

  logic                         enable_before_r;
  logic [ssm_pkg::POS_W-1:0]    scroll_position_r;
  logic [ssm_pkg::PERIOD_W-1:0] tick_count_r;
  logic [ssm_pkg::BANK_W-1:0]   shown_right_r;
  logic [ssm_pkg::BANK_W-1:0]   shown_left_r;
  logic                         out_valid_r;
  logic                         step_r;

  logic [ssm_pkg::CNT_W-1:0]    cnt_r;
  logic [ssm_pkg::POS_W-1:0]    idx_r;
  logic [ssm_pkg::LEN_W-1:0]    len_q_r;
  logic [WIN_W-1:0]             win_r;
  logic [ssm_pkg::BANK_W-1:0]   out_right_r;
  logic [ssm_pkg::BANK_W-1:0]   out_left_r;

  logic                         in_fire;
  logic                         cfg_wr;
  logic                         out_load;
  logic                         en_rise;
  logic                         tick_ge;
  logic                         need_latch;
  logic [ssm_pkg::LEN_W-1:0]    len_eff;
  logic [ssm_pkg::POS_W-1:0]    pos_eff;
  logic [ssm_pkg::POS_W-1:0]    pos_mod;
  logic [ssm_pkg::LEN_W-1:0]    idx_inc;
  logic [ssm_pkg::POS_W-1:0]    idx_nxt;
  logic [ssm_pkg::CODE_W-1:0]   code;
  logic [WIN_W-1:0]             win_nxt;
  logic [2*ssm_pkg::DATA_W-1:0] msg_bytes;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign pready      = 1'b1;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.right_digits = out_right_r;
  assign out_ch.left_digits  = out_left_r;

  always_comb begin
    unique case (paddr[ssm_pkg::ADDR_W-1 -: ssm_pkg::REGSEL_W])
      ssm_pkg::REG_MSG_LO: prdata = message_chars_lo_r;
      ssm_pkg::REG_MSG_HI: prdata = message_chars_hi_r;
      ssm_pkg::REG_LENGTH: prdata = ssm_pkg::DATA_W'(message_length_r);
      ssm_pkg::REG_PERIOD: prdata = ssm_pkg::DATA_W'(scroll_period_r);
    endcase
  end

  // clamp length into 1..MESSAGE_MAX
  always_comb begin
    if (message_length_r == '0) begin
      len_eff = ssm_pkg::LEN_W'(1);
    end else if (message_length_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = message_length_r;
    end
  end

  assign en_rise    = in_ch.display_enable && !enable_before_r;
  assign pos_eff    = en_rise ? '0 : scroll_position_r;
  assign tick_ge    = (tick_count_r >= scroll_period_r);
  assign need_latch = in_ch.display_enable && (!in_ch.scroll_enable || tick_ge);

  // start index: position mod length by four restoring steps
  always_comb begin
    logic [MOD_W-1:0] rem;
    logic [MOD_W-1:0] dsub;
    rem = MOD_W'(pos_eff);
    for (int k = ssm_pkg::POS_W - 1; k >= 0; k--) begin
      dsub = MOD_W'(len_eff) << k;
      if (rem >= dsub) begin
        rem = rem - dsub;
      end
    end
    pos_mod = rem[ssm_pkg::POS_W-1:0];
  end

  // shared digit unit: fetch, encode, advance with wrap
  assign msg_bytes = {message_chars_hi_r, message_chars_lo_r};
  assign code      = ssm_pkg::encode_char(msg_bytes[idx_r*ssm_pkg::CODE_W +: ssm_pkg::CODE_W]);
  assign idx_inc   = ssm_pkg::LEN_W'(idx_r) + ssm_pkg::LEN_W'(1);
  assign idx_nxt   = (idx_inc == len_q_r) ? '0 : idx_inc[ssm_pkg::POS_W-1:0];
  assign win_nxt   = {win_r[WIN_W-ssm_pkg::CODE_W-1:0], code};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = need_latch ? ST_WIN : ST_DONE;
        end
      end
      ST_WIN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      message_chars_lo_r <= '0;
      message_chars_hi_r <= '0;
      message_length_r   <= ssm_pkg::RESET_LENGTH;
      scroll_period_r    <= ssm_pkg::RESET_PERIOD;
      enable_before_r    <= 1'b0;
      scroll_position_r  <= '0;
      tick_count_r       <= '0;
      shown_right_r      <= ssm_pkg::BLANK_BANK;
      shown_left_r       <= ssm_pkg::BLANK_BANK;
      out_valid_r        <= 1'b0;
      step_r             <= 1'b0;
      cnt_r              <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (paddr[ssm_pkg::ADDR_W-1 -: ssm_pkg::REGSEL_W])
          ssm_pkg::REG_MSG_LO: message_chars_lo_r <= pwdata;
          ssm_pkg::REG_MSG_HI: message_chars_hi_r <= pwdata;
          ssm_pkg::REG_LENGTH: message_length_r   <= pwdata[ssm_pkg::LEN_W-1:0];
          ssm_pkg::REG_PERIOD: scroll_period_r    <= pwdata[ssm_pkg::PERIOD_W-1:0];
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        enable_before_r <= in_ch.display_enable;
        step_r          <= in_ch.scroll_enable && tick_ge;
        cnt_r           <= '0;
        if (!in_ch.display_enable) begin
          shown_right_r <= ssm_pkg::BLANK_BANK;
          shown_left_r  <= ssm_pkg::BLANK_BANK;
        end else begin
          scroll_position_r <= pos_eff;
          if (in_ch.scroll_enable) begin
            tick_count_r <= tick_ge ? ssm_pkg::PERIOD_W'(1)
                                    : tick_count_r + ssm_pkg::PERIOD_W'(1);
          end
        end
      end

      if (state_r == ST_WIN) begin
        cnt_r <= cnt_r + ssm_pkg::CNT_W'(1);
        // next position is the index after the first window character
        if (cnt_r == '0 && step_r) begin
          scroll_position_r <= idx_nxt;
        end
        if (cnt_r == CNT_LAST) begin
          shown_left_r  <= win_nxt[WIN_W-1 -: ssm_pkg::BANK_W];
          shown_right_r <= win_nxt[ssm_pkg::BANK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r   <= pos_mod;
      len_q_r <= len_eff;
    end else if (state_r == ST_WIN) begin
      idx_r <= idx_nxt;
      win_r <= win_nxt;
    end
    if (out_load) begin
      out_right_r <= shown_right_r;
      out_left_r  <= shown_left_r;
    end
  end

  `SSM_ASSERT_NEXT(a_blank_tick, in_fire && !in_ch.display_enable, (state_r == ST_DONE) && (shown_left_r == ssm_pkg::BLANK_BANK) && (shown_right_r == ssm_pkg::BLANK_BANK), "disabled tick did not blank both banks")
  `SSM_ASSERT_NOW(a_idx_in_range, state_r == ST_WIN, ssm_pkg::LEN_W'(idx_r) < len_q_r, "window index not below message length")
  `SSM_ASSERT_NOW(a_cnt_in_range, state_r == ST_WIN, cnt_r <= CNT_LAST, "digit counter past last digit")

endmodule
